[design/tir_pkg.sv]
// Shared types and constants for the timed ID recycler.
// Holds command and status codes and the controller/datapath interface structs.
// No dependencies.
package tir_pkg;

    localparam int POOL_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF    = 32;

    localparam logic [15:0] DELAY_RESET = 16'd1000;

    // Command codes on the command port
    localparam logic [1:0] CMD_GAIN    = 2'd0;
    localparam logic [1:0] CMD_RECYCLE = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NONNEG    = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED = 2'd3;

    // Kind of result the controller asks the datapath to register
    typedef enum logic [1:0] {
        RES_GAIN,
        RES_OK,
        RES_NONNEG,
        RES_FULL
    } tir_res_t;

    typedef struct packed {
        logic     load;        // latch the input beat, restart the scan
        logic     rd_head;     // read the head entry
        logic     scan_issue;  // read the entry at the scan index, advance
        logic     match_wr;    // clear the age of the matching entry
        logic     age_wr;      // age the entry returned by the scan
        logic     append;      // append the latched ID at the tail
        logic     fin;         // register a result beat
        tir_res_t res;
    } tir_cmd_t;

    typedef struct packed {
        logic id_neg;  // incoming ID is negative
        logic more;    // scan index below the fill count
        logic pend;    // scan read data valid this cycle
        logic hit;     // scan read data matches the latched ID
        logic full;    // FIFO holds POOL_DEPTH entries
    } tir_stat_t;

endpackage

[design/tir_ctrl.sv]
// Controller of the timed ID recycler: sequences gain, recycle scan and tick scan.
// Depends on tir_pkg for the command/status structs and codes.
module tir_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          command,
    input  tir_pkg::tir_stat_t  stat,
    output tir_pkg::tir_cmd_t   cmd,
    output logic                busy
);
    import tir_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAIN_RD,
        S_GAIN_FIN,
        S_REC_SCAN,
        S_TICK_SCAN
    } state_t;

    state_t state_reg, state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res    = RES_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (command)
                        CMD_GAIN:    state_next = S_GAIN_RD;
                        CMD_RECYCLE:
                        begin
                            if (stat.id_neg)
                            begin
                                state_next = S_REC_SCAN;
                            end
                            else
                            begin
                                cmd.fin = 1'b1;
                                cmd.res = RES_NONNEG;
                            end
                        end
                        CMD_TICK:    state_next = S_TICK_SCAN;
                        default:     cmd.fin = 1'b1;
                    endcase
                end
            end
            S_GAIN_RD:
            begin
                cmd.rd_head = 1'b1;
                state_next  = S_GAIN_FIN;
            end
            S_GAIN_FIN:
            begin
                cmd.fin    = 1'b1;
                cmd.res    = RES_GAIN;
                state_next = S_IDLE;
            end
            S_REC_SCAN:
            begin
                if (stat.hit)
                begin
                    // already queued: restart its quarantine
                    cmd.match_wr = 1'b1;
                    cmd.fin      = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (stat.more)
                begin
                    cmd.scan_issue = 1'b1;
                end
                else if (!stat.pend)
                begin
                    cmd.fin = 1'b1;
                    if (stat.full)
                    begin
                        cmd.res = RES_FULL;
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_TICK_SCAN:
            begin
                cmd.age_wr = 1'b1;
                if (stat.more)
                begin
                    cmd.scan_issue = 1'b1;
                end
                else if (!stat.pend)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[design/tir_dpath.sv]
// Datapath of the timed ID recycler: ID and age memories, FIFO pointers,
// fresh counter, reuse delay register and result registers. Depends on tir_pkg.
module tir_dpath #(
    parameter int POOL_DEPTH = tir_pkg::POOL_DEPTH_DEF,
    parameter int ID_BITS    = tir_pkg::ID_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         id_in,
    input  logic [15:0]         delta_time,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  tir_pkg::tir_cmd_t   cmd,
    output tir_pkg::tir_stat_t  stat,
    output logic                done,
    output logic [31:0]         id_out,
    output logic                from_pool,
    output logic [1:0]          status
);
    import tir_pkg::*;

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C   = CW'(POOL_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(POOL_DEPTH - 1);
    localparam logic signed [ID_BITS-1:0] FRESH_MIN = {1'b1, {(ID_BITS - 1){1'b0}}};

    // (base + off) mod POOL_DEPTH with base < POOL_DEPTH and off <= POOL_DEPTH
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW + 1)'(base) + (CW + 1)'(off);
        if (sum >= (CW + 1)'(POOL_DEPTH))
        begin
            sum = sum - (CW + 1)'(POOL_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [31:0] ids_mem  [POOL_DEPTH];
    logic [15:0] ages_mem [POOL_DEPTH];

    logic [15:0]               delay_reg;
    logic [AW-1:0]             head_reg, head_next;
    logic [CW-1:0]             count_reg, count_next;
    logic signed [ID_BITS-1:0] fresh_reg, fresh_next;
    logic [CW-1:0]             idx_reg, idx_next;
    logic                      pend_reg, pend_next;
    logic [AW-1:0]             pipe_slot_reg;
    logic [31:0]               id_reg;
    logic [15:0]               dt_reg;
    logic [31:0]               rd_id_reg;
    logic [15:0]               rd_age_reg;
    logic                      done_reg;
    logic [31:0]               id_out_reg, id_out_next;
    logic                      from_pool_reg, from_pool_next;
    logic [1:0]                status_reg, status_next;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] scan_slot;
    logic [AW-1:0] tail_slot;
    logic          age_we;
    logic [AW-1:0] age_waddr;
    logic [15:0]   age_wdata;
    logic [16:0]   age_sum;
    logic [15:0]   age_sat;
    logic          age_young;
    logic          reuse;

    assign scan_slot = slot_of(head_reg, idx_reg);
    assign tail_slot = slot_of(head_reg, count_reg);
    assign rd_en     = cmd.rd_head | cmd.scan_issue;
    assign rd_addr   = cmd.rd_head ? head_reg : scan_slot;

    assign stat.id_neg = id_in[31];
    assign stat.more   = (idx_reg < count_reg);
    assign stat.pend   = pend_reg;
    assign stat.hit    = pend_reg && (rd_id_reg == id_reg);
    assign stat.full   = (count_reg == DEPTH_C);

    assign age_sum   = {1'b0, rd_age_reg} + {1'b0, dt_reg};
    assign age_sat   = age_sum[16] ? 16'hFFFF : age_sum[15:0];
    assign age_young = (rd_age_reg <= delay_reg);
    assign reuse     = (count_reg != '0) && (rd_age_reg > delay_reg);

    always_comb
    begin
        age_we    = 1'b0;
        age_waddr = pipe_slot_reg;
        age_wdata = '0;
        if (cmd.append)
        begin
            age_we    = 1'b1;
            age_waddr = tail_slot;
        end
        else if (cmd.match_wr)
        begin
            age_we = 1'b1;
        end
        else if (cmd.age_wr && pend_reg && age_young)
        begin
            age_we    = 1'b1;
            age_wdata = age_sat;
        end
    end

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        fresh_next     = fresh_reg;
        idx_next       = idx_reg;
        pend_next      = cmd.scan_issue;
        id_out_next    = id_out_reg;
        from_pool_next = from_pool_reg;
        status_next    = status_reg;

        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.scan_issue)
        begin
            idx_next = idx_reg + 1'b1;
        end

        if (cmd.append)
        begin
            count_next = count_reg + 1'b1;
        end

        if (cmd.fin)
        begin
            id_out_next    = '0;
            from_pool_next = 1'b0;
            status_next    = ST_OK;
            case (cmd.res)
                RES_GAIN:
                begin
                    if (reuse)
                    begin
                        id_out_next    = rd_id_reg;
                        from_pool_next = 1'b1;
                        head_next      = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                        count_next     = count_reg - 1'b1;
                    end
                    else if (fresh_reg == FRESH_MIN)
                    begin
                        status_next = ST_EXHAUSTED;
                    end
                    else
                    begin
                        id_out_next = 32'(fresh_reg);
                        fresh_next  = fresh_reg - 1'b1;
                    end
                end
                RES_NONNEG: status_next = ST_NONNEG;
                RES_FULL:   status_next = ST_FULL;
                default:    status_next = ST_OK;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= DELAY_RESET;
            head_reg  <= '0;
            count_reg <= '0;
            fresh_reg <= '1;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                delay_reg <= cfg_wr_data;
            end
            head_reg  <= head_next;
            count_reg <= count_next;
            fresh_reg <= fresh_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            done_reg  <= cmd.fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg <= id_in;
            dt_reg <= delta_time;
        end
        if (cmd.scan_issue)
        begin
            pipe_slot_reg <= scan_slot;
        end
        id_out_reg    <= id_out_next;
        from_pool_reg <= from_pool_next;
        status_reg    <= status_next;
    end

    // ID and age memories: one write port each, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            ids_mem[tail_slot] <= id_reg;
        end
        if (age_we)
        begin
            ages_mem[age_waddr] <= age_wdata;
        end
        if (rd_en)
        begin
            rd_id_reg  <= ids_mem[rd_addr];
            rd_age_reg <= ages_mem[rd_addr];
        end
    end

    assign done      = done_reg;
    assign id_out    = id_out_reg;
    assign from_pool = from_pool_reg;
    assign status    = status_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("fill count beyond pool depth");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> (count_reg < DEPTH_C))
        else $error("append into a full pool");

    a_pend_issue: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(cmd.scan_issue))
        else $error("scan data valid without a read");

    a_reuse_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && from_pool_reg) |-> (count_reg + 1'b1 == $past(count_reg)))
        else $error("pool grant did not pop the head");
`endif

endmodule

[design/timed_id_recycler_core.sv]
// Top level of the timed ID recycler: controller plus datapath.
// Depends on tir_pkg, tir_ctrl and tir_dpath.
//
// Usage:
//   Command channel: drive command, id_in and delta_time with start high; the
//   beat is taken at a rising edge where start is high and busy is low.
//   Result channel: done pulses for one cycle with id_out, from_pool and status;
//   the receiver cannot stall and must take the beat in that cycle.
//   Configuration: cfg_wr_en with cfg_wr_data writes reuse_delay at the edge;
//   write only while the block is idle.
// Sequencing and throughput:
//   gain steps through a head read, a decision and the result register.
//   recycle of a negative ID and tick walk the FIFO one entry per cycle through
//   the single memory read port, stopping early when a recycle finds its ID.
//   Other commands are answered from the idle state. One command is in flight
//   at a time; the next beat can be taken at the edge that takes the result.
// Reset:
//   asynchronous, clears the FIFO pointers, sets the fresh counter to -1 and
//   reuse_delay to 1000. Memory contents are not cleared; only written entries
//   ever affect a result.
module timed_id_recycler_core #(
    parameter int POOL_DEPTH = tir_pkg::POOL_DEPTH_DEF,
    parameter int ID_BITS    = tir_pkg::ID_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [31:0] id_in,
    input  logic [15:0] delta_time,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output logic        done,
    output logic [31:0] id_out,
    output logic        from_pool,
    output logic [1:0]  status
);
    import tir_pkg::*;

    tir_cmd_t  cmd;
    tir_stat_t stat;

    tir_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    tir_dpath #(
        .POOL_DEPTH (POOL_DEPTH),
        .ID_BITS    (ID_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .id_in       (id_in),
        .delta_time  (delta_time),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .done        (done),
        .id_out      (id_out),
        .from_pool   (from_pool),
        .status      (status)
    );

endmodule
